### rtl/gpi_pkg.sv
// Shared types, constants and helpers of the gravity pair interaction block.
`default_nettype none

package gpi_pkg;

    // Default fraction bits of positions and velocities
    localparam int FRAC_BITS_DEF = 16;

    // Fixed formats of the item fields
    localparam int MASS_FRAC     = 8;   // mass is Q24.8
    localparam int TIME_FRAC     = 16;  // time step is Q0.16
    localparam int DV_SCALE_BITS = 24;  // last divisor is d shifted by this minus FRAC_BITS

    // Datapath widths
    localparam int MD_W     = 64;  // operand and quotient width of the mul-div pipe
    localparam int SQ_STEPS = 33;  // root bits of the 66-bit squared distance
    localparam int SAT_W    = 40;  // width of sums fed to the saturator

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_W-1:0] GAIN_RST = 16'd999;
    localparam logic [CFG_W-1:0] CDIV_RST = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN = 1'b0,
        CFG_CDIV = 1'b1
    } t_cfg_idx;

    // Stream word widths, padded to whole bytes
    localparam int IN_W  = 280;
    localparam int OUT_W = 200;

    // Input word, first field in the lowest bits
    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] delta_time;
        logic        other_gone;
        logic [31:0] other_mass;
        logic [31:0] other_y;
        logic [31:0] other_x;
        logic        self_gone;
        logic        self_fixed;
        logic [31:0] self_mass;
        logic [31:0] self_vy;
        logic [31:0] self_vx;
        logic [31:0] self_y;
        logic [31:0] self_x;
    } t_in_word;

    // Output word, first field in the lowest bits
    typedef struct packed {
        logic [4:0]  pad;
        logic        other_velocity_cleared;
        logic        other_removed;
        logic [31:0] new_other_mass;
        logic        self_removed;
        logic [31:0] new_self_mass;
        logic [31:0] new_vy;
        logic [31:0] new_vx;
        logic [31:0] new_y;
        logic [31:0] new_x;
    } t_out_word;

    // Per-pair state carried alongside the long arithmetic
    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] ms;
        logic [31:0] mo;
        logic [31:0] msat;
        logic        fixed;
        logic        sgone;
        logic        ogone;
        logic [15:0] t;
        logic        negx;
        logic        negy;
        logic        dnz;
        logic        merge;
    } t_pay;

    // State carried through the square root
    typedef struct packed {
        t_pay        pay;
        logic [63:0] q;
        logic [32:0] ax;
        logic [32:0] ay;
        logic [32:0] msum;
    } t_side;

    // Clamp a signed sum to the 32-bit signed range
    function automatic logic [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic [31:0] res;
        if (v > 40'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/gpi_muldiv_pipe.sv
// Two-lane pipelined floor(a*b/c) with saturation to all ones on quotient overflow.
`default_nettype none

module gpi_muldiv_pipe #(
    parameter int PAY_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_ce,
    input  logic                     i_valid,
    input  logic [gpi_pkg::MD_W-1:0] i_a_x,
    input  logic [gpi_pkg::MD_W-1:0] i_a_y,
    input  logic [gpi_pkg::MD_W-1:0] i_b_x,
    input  logic [gpi_pkg::MD_W-1:0] i_b_y,
    input  logic [gpi_pkg::MD_W-1:0] i_c,
    input  logic [PAY_W-1:0]         i_pay,
    output logic                     o_valid,
    output logic [gpi_pkg::MD_W-1:0] o_q_x,
    output logic [gpi_pkg::MD_W-1:0] o_q_y,
    output logic [gpi_pkg::MD_W-1:0] o_c,
    output logic [PAY_W-1:0]         o_pay
);
    import gpi_pkg::*;

    localparam int HW    = MD_W / 2;
    localparam int STEPS = MD_W;

    logic [MD_W-1:0] w_a [0:1];
    logic [MD_W-1:0] w_b [0:1];

    assign w_a[0] = i_a_x;
    assign w_a[1] = i_a_y;
    assign w_b[0] = i_b_x;
    assign w_b[1] = i_b_y;

    // Partial products stage
    logic [MD_W-1:0]  r_p0 [0:1];
    logic [MD_W-1:0]  r_p1 [0:1];
    logic [MD_W-1:0]  r_p2 [0:1];
    logic [MD_W-1:0]  r_p3 [0:1];
    logic [MD_W-1:0]  r_c1;
    logic [PAY_W-1:0] r_pay1;
    logic             r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_ce) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int l = 0; l < 2; l++) begin
                r_p0[l] <= w_a[l][HW-1:0]    * w_b[l][HW-1:0];
                r_p1[l] <= w_a[l][HW-1:0]    * w_b[l][MD_W-1:HW];
                r_p2[l] <= w_a[l][MD_W-1:HW] * w_b[l][HW-1:0];
                r_p3[l] <= w_a[l][MD_W-1:HW] * w_b[l][MD_W-1:HW];
            end
            r_c1   <= i_c;
            r_pay1 <= i_pay;
        end
    end

    // Division state, one stage per quotient bit
    logic [MD_W-1:0]  r_rem [0:STEPS-1][0:1];
    logic [MD_W-1:0]  r_lo  [0:STEPS-1][0:1];
    logic [MD_W-1:0]  r_quo [1:STEPS][0:1];
    logic             r_sat [0:STEPS][0:1];
    logic [MD_W-1:0]  r_c   [0:STEPS];
    logic [PAY_W-1:0] r_pay [0:STEPS];
    logic             r_v   [0:STEPS];

    // Sum partial products and check the quotient fits
    logic [2*MD_W-1:0] n_prod [0:1];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_prod[l] = {{MD_W{1'b0}}, r_p0[l]}
                      + {{HW{1'b0}}, r_p1[l], {HW{1'b0}}}
                      + {{HW{1'b0}}, r_p2[l], {HW{1'b0}}}
                      + {r_p3[l], {MD_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ce) begin
            r_v[0] <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int l = 0; l < 2; l++) begin
                r_rem[0][l] <= n_prod[l][2*MD_W-1:MD_W];
                r_lo[0][l]  <= n_prod[l][MD_W-1:0];
                r_sat[0][l] <= n_prod[l][2*MD_W-1:MD_W] >= r_c1;
            end
            r_c[0]   <= r_c1;
            r_pay[0] <= r_pay1;
        end
    end

    // Restoring division stages
    for (genvar gi = 0; gi < STEPS; gi++) begin : g_div
        logic [MD_W-1:0] w_qin  [0:1];
        logic [MD_W-1:0] n_sh   [0:1];
        logic [MD_W-1:0] n_rem  [0:1];
        logic [MD_W-1:0] n_quo  [0:1];
        logic            n_ge   [0:1];

        if (gi == 0) begin : g_first
            assign w_qin[0] = '0;
            assign w_qin[1] = '0;
        end else begin : g_next
            assign w_qin[0] = r_quo[gi][0];
            assign w_qin[1] = r_quo[gi][1];
        end

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                n_sh[l]  = {r_rem[gi][l][MD_W-2:0], r_lo[gi][l][MD_W-1]};
                n_ge[l]  = n_sh[l] >= r_c[gi];
                n_rem[l] = n_ge[l] ? (n_sh[l] - r_c[gi]) : n_sh[l];
                n_quo[l] = {w_qin[l][MD_W-2:0], n_ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gi+1] <= 1'b0;
            end else if (i_ce) begin
                r_v[gi+1] <= r_v[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                for (int l = 0; l < 2; l++) begin
                    r_quo[gi+1][l] <= n_quo[l];
                    r_sat[gi+1][l] <= r_sat[gi][l];
                end
                r_c[gi+1]   <= r_c[gi];
                r_pay[gi+1] <= r_pay[gi];
            end
        end

        if (gi < STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    for (int l = 0; l < 2; l++) begin
                        r_rem[gi+1][l] <= n_rem[l];
                        r_lo[gi+1][l]  <= {r_lo[gi][l][MD_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_valid = r_v[STEPS];
    assign o_q_x   = r_sat[STEPS][0] ? {MD_W{1'b1}} : r_quo[STEPS][0];
    assign o_q_y   = r_sat[STEPS][1] ? {MD_W{1'b1}} : r_quo[STEPS][1];
    assign o_c     = r_c[STEPS];
    assign o_pay   = r_pay[STEPS];

endmodule

`default_nettype wire

### rtl/gravity_pair_interaction.sv
// Top level of the gravity pair interaction pipeline.
//
// One input word on s_axis carries a self particle, the other particle's
// position, mass and removed flag, and a time step. Each word gives exactly
// one output word on m_axis with the updated self state and merge flags.
// A word is moved when tvalid and tready are both high.
// One word can be accepted every cycle while the pipeline is not held. The
// depth comes from the 33-stage square root and three 66-stage mul-div pipes
// (one quotient bit per division stage).
// When the receiver stalls, the pipeline keeps advancing while the stage in
// front of the output register holds a bubble, so new words are still taken;
// once a valid word is queued behind the held output, the whole pipeline and
// s_axis_tready hold until m_axis_tready returns. Nothing is lost or repeated.
// Reset clears all valid bits and loads the default gain and divisor; the
// configuration port writes a register at any edge with i_cfg_wr_en high and
// is meant to be used while no words are in flight.
`default_nettype none

module gravity_pair_interaction #(
    parameter int FRAC_BITS = gpi_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_wr_en,
    input  logic [gpi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gpi_pkg::CFG_W-1:0]     i_cfg_wdata,
    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata from bit 0: self_x, self_y, self_vx, self_vy, self_mass, self_fixed,
    // self_gone, other_x, other_y, other_mass, other_gone, delta_time, zero pad
    input  logic [gpi_pkg::IN_W-1:0]      s_axis_tdata,
    // Output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata from bit 0: new_x, new_y, new_vx, new_vy, new_self_mass, self_removed,
    // new_other_mass, other_removed, other_velocity_cleared, zero pad
    output logic [gpi_pkg::OUT_W-1:0]     m_axis_tdata
);
    import gpi_pkg::*;

    localparam int PAY_W   = $bits(t_pay);
    localparam int C_SHIFT = DV_SCALE_BITS - FRAC_BITS;

    // Configuration registers
    logic [CFG_W-1:0] r_gain;
    logic [CFG_W-1:0] r_cdiv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RST;
            r_cdiv <= CDIV_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_GAIN: r_gain <= i_cfg_wdata;
                CFG_CDIV: r_cdiv <= i_cfg_wdata;
                default:  r_gain <= r_gain;
            endcase
        end
    end

    // Pipeline advance
    logic      w_ce;
    logic      r_vp;
    logic      r_out_valid;
    t_out_word r_out;

    assign w_ce          = m_axis_tready || !r_out_valid || !r_vp;
    assign s_axis_tready = w_ce;

    // Stage 1: capture the word
    t_in_word r1_word;
    logic     r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_ce) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r1_word <= t_in_word'(s_axis_tdata);
        end
    end

    // Stage 2: differences, magnitudes, mass sum, first gain product
    logic [32:0] n2_dx;
    logic [32:0] n2_dy;
    t_side       n2_side;
    logic [47:0] n2_gq1;
    t_side       r2_side;
    logic [47:0] r2_gq1;
    logic        r_v2;

    always_comb begin
        n2_dx = {r1_word.other_x[31], r1_word.other_x} - {r1_word.self_x[31], r1_word.self_x};
        n2_dy = {r1_word.other_y[31], r1_word.other_y} - {r1_word.self_y[31], r1_word.self_y};
        n2_side            = '0;
        n2_side.pay.sx     = r1_word.self_x;
        n2_side.pay.sy     = r1_word.self_y;
        n2_side.pay.vx     = r1_word.self_vx;
        n2_side.pay.vy     = r1_word.self_vy;
        n2_side.pay.ms     = r1_word.self_mass;
        n2_side.pay.mo     = r1_word.other_mass;
        n2_side.pay.fixed  = r1_word.self_fixed;
        n2_side.pay.sgone  = r1_word.self_gone;
        n2_side.pay.ogone  = r1_word.other_gone;
        n2_side.pay.t      = r1_word.delta_time;
        n2_side.pay.negx   = n2_dx[32];
        n2_side.pay.negy   = n2_dy[32];
        n2_side.ax         = n2_dx[32] ? (~n2_dx + 33'd1) : n2_dx;
        n2_side.ay         = n2_dy[32] ? (~n2_dy + 33'd1) : n2_dy;
        n2_side.msum       = {1'b0, r1_word.self_mass} + {1'b0, r1_word.other_mass};
        n2_gq1             = {32'b0, r_gain} * {16'b0, r1_word.other_mass};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_ce) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r2_side <= n2_side;
            r2_gq1  <= n2_gq1;
        end
    end

    // Stage 3: squares and full force numerator
    logic [65:0] r3_a2;
    logic [65:0] r3_b2;
    t_side       n3_side;
    t_side       r3_side;
    logic        r_v3;

    always_comb begin
        n3_side   = r2_side;
        n3_side.q = {16'b0, r2_gq1} * {48'b0, r2_side.pay.t};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_ce) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r3_a2   <= {33'b0, r2_side.ax} * {33'b0, r2_side.ax};
            r3_b2   <= {33'b0, r2_side.ay} * {33'b0, r2_side.ay};
            r3_side <= n3_side;
        end
    end

    // Stage 4 loads the square root pipe with the squared distance
    logic [65:0] r_sq_n    [0:SQ_STEPS-1];
    logic [33:0] r_sq_rem  [0:SQ_STEPS-1];
    logic [32:0] r_sq_root [0:SQ_STEPS];
    t_side       r_sq_side [0:SQ_STEPS];
    logic        r_sq_v    [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (w_ce) begin
            r_sq_v[0] <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_sq_n[0]    <= r3_a2 + r3_b2;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_side[0] <= r3_side;
        end
    end

    // Digit-by-digit square root, one root bit per stage
    for (genvar gi = 0; gi < SQ_STEPS; gi++) begin : g_sq
        logic [35:0] n_sh;
        logic [35:0] n_trial;
        logic        n_ge;

        always_comb begin
            n_sh    = {r_sq_rem[gi], r_sq_n[gi][65:64]};
            n_trial = {1'b0, r_sq_root[gi], 2'b01};
            n_ge    = n_sh >= n_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[gi+1] <= 1'b0;
            end else if (w_ce) begin
                r_sq_v[gi+1] <= r_sq_v[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_sq_root[gi+1] <= {r_sq_root[gi][31:0], n_ge};
                r_sq_side[gi+1] <= r_sq_side[gi];
            end
        end

        if (gi < SQ_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_ce) begin
                    r_sq_rem[gi+1] <= n_ge ? 34'(n_sh - n_trial) : 34'(n_sh);
                    r_sq_n[gi+1]   <= {r_sq_n[gi][63:0], 2'b00};
                end
            end
        end
    end

    // Merge test, first stage: distance times divisor
    logic [48:0] r_m1_mp;
    logic [32:0] r_m1_d;
    t_side       r_m1_side;
    logic        r_m1_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
        end else if (w_ce) begin
            r_m1_v <= r_sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_m1_mp   <= {16'b0, r_sq_root[SQ_STEPS]} * {33'b0, r_cdiv};
            r_m1_d    <= r_sq_root[SQ_STEPS];
            r_m1_side <= r_sq_side[SQ_STEPS];
        end
    end

    // Merge test, second stage: compare against summed mass
    t_pay            n_m2_pay;
    t_pay            r_m2_pay;
    logic [MD_W-1:0] r_m2_q;
    logic [MD_W-1:0] r_m2_ax;
    logic [MD_W-1:0] r_m2_ay;
    logic [MD_W-1:0] r_m2_d;
    logic            r_m2_v;

    always_comb begin
        n_m2_pay       = r_m1_side.pay;
        n_m2_pay.merge = (64'(r_m1_mp) << MASS_FRAC) < (64'(r_m1_side.msum) << FRAC_BITS);
        n_m2_pay.msat  = r_m1_side.msum[32] ? 32'hFFFF_FFFF : r_m1_side.msum[31:0];
        n_m2_pay.dnz   = r_m1_d != 33'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_v <= 1'b0;
        end else if (w_ce) begin
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_m2_pay <= n_m2_pay;
            r_m2_q   <= r_m1_side.q;
            r_m2_ax  <= 64'(r_m1_side.ax);
            r_m2_ay  <= 64'(r_m1_side.ay);
            r_m2_d   <= 64'(r_m1_d);
        end
    end

    // Force chain: A = q*|d|/dist, B = A*2^F/dist, C = B*2^F/(dist << shift)
    logic            w_ma_v;
    logic [MD_W-1:0] w_ma_qx;
    logic [MD_W-1:0] w_ma_qy;
    logic [MD_W-1:0] w_ma_c;
    t_pay            w_ma_pay;

    gpi_muldiv_pipe #(
        .PAY_W (PAY_W)
    ) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (r_m2_v),
        .i_a_x   (r_m2_q),
        .i_a_y   (r_m2_q),
        .i_b_x   (r_m2_ax),
        .i_b_y   (r_m2_ay),
        .i_c     (r_m2_d),
        .i_pay   (r_m2_pay),
        .o_valid (w_ma_v),
        .o_q_x   (w_ma_qx),
        .o_q_y   (w_ma_qy),
        .o_c     (w_ma_c),
        .o_pay   (w_ma_pay)
    );

    logic            w_mb_v;
    logic [MD_W-1:0] w_mb_qx;
    logic [MD_W-1:0] w_mb_qy;
    logic [MD_W-1:0] w_mb_c;
    t_pay            w_mb_pay;
    logic [MD_W-1:0] w_frac_one;

    assign w_frac_one = 64'(1) << FRAC_BITS;

    gpi_muldiv_pipe #(
        .PAY_W (PAY_W)
    ) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_ma_v),
        .i_a_x   (w_ma_qx),
        .i_a_y   (w_ma_qy),
        .i_b_x   (w_frac_one),
        .i_b_y   (w_frac_one),
        .i_c     (w_ma_c),
        .i_pay   (w_ma_pay),
        .o_valid (w_mb_v),
        .o_q_x   (w_mb_qx),
        .o_q_y   (w_mb_qy),
        .o_c     (w_mb_c),
        .o_pay   (w_mb_pay)
    );

    logic            w_mc_v;
    logic [MD_W-1:0] w_mc_qx;
    logic [MD_W-1:0] w_mc_qy;
    t_pay            w_mc_pay;

    gpi_muldiv_pipe #(
        .PAY_W (PAY_W)
    ) u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_mb_v),
        .i_a_x   (w_mb_qx),
        .i_a_y   (w_mb_qy),
        .i_b_x   (w_frac_one),
        .i_b_y   (w_frac_one),
        .i_c     (w_mb_c << C_SHIFT),
        .i_pay   (w_mb_pay),
        .o_valid (w_mc_v),
        .o_q_x   (w_mc_qx),
        .o_q_y   (w_mc_qy),
        .o_c     (),
        .o_pay   (w_mc_pay)
    );

    // Velocity stage: clamp, sign and add the velocity step
    logic [32:0] n_v_cx;
    logic [32:0] n_v_cy;
    logic [33:0] n_v_dvx;
    logic [33:0] n_v_dvy;
    logic [31:0] n_v_wx;
    logic [31:0] n_v_wy;
    logic [31:0] r_v_wx;
    logic [31:0] r_v_wy;
    t_pay        r_v_pay;
    logic        r_v_v;

    always_comb begin
        n_v_cx  = (w_mc_qx > 64'h1_0000_0000) ? 33'h1_0000_0000 : w_mc_qx[32:0];
        n_v_cy  = (w_mc_qy > 64'h1_0000_0000) ? 33'h1_0000_0000 : w_mc_qy[32:0];
        n_v_dvx = w_mc_pay.negx ? (~{1'b0, n_v_cx} + 34'd1) : {1'b0, n_v_cx};
        n_v_dvy = w_mc_pay.negy ? (~{1'b0, n_v_cy} + 34'd1) : {1'b0, n_v_cy};
        n_v_wx  = w_mc_pay.vx;
        n_v_wy  = w_mc_pay.vy;
        if (w_mc_pay.dnz) begin
            n_v_wx = sat32({{8{w_mc_pay.vx[31]}}, w_mc_pay.vx}
                         + {{6{n_v_dvx[33]}}, n_v_dvx});
            n_v_wy = sat32({{8{w_mc_pay.vy[31]}}, w_mc_pay.vy}
                         + {{6{n_v_dvy[33]}}, n_v_dvy});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_v <= 1'b0;
        end else if (w_ce) begin
            r_v_v <= w_mc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_v_wx  <= n_v_wx;
            r_v_wy  <= n_v_wy;
            r_v_pay <= w_mc_pay;
        end
    end

    // Displacement stage: new velocity times time step
    logic signed [48:0] r_p_px;
    logic signed [48:0] r_p_py;
    logic [31:0]        r_p_wx;
    logic [31:0]        r_p_wy;
    t_pay               r_p_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else if (w_ce) begin
            r_vp <= r_v_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_p_px  <= $signed(r_v_wx) * $signed({1'b0, r_v_pay.t});
            r_p_py  <= $signed(r_v_wy) * $signed({1'b0, r_v_pay.t});
            r_p_wx  <= r_v_wx;
            r_p_wy  <= r_v_wy;
            r_p_pay <= r_v_pay;
        end
    end

    // Output select: pass, merge, or move
    logic [32:0] n_o_mvx;
    logic [32:0] n_o_mvy;
    t_out_word   n_out;

    always_comb begin
        n_o_mvx = r_p_px[48:TIME_FRAC];
        n_o_mvy = r_p_py[48:TIME_FRAC];
        n_out                        = '0;
        n_out.new_x                  = r_p_pay.sx;
        n_out.new_y                  = r_p_pay.sy;
        n_out.new_vx                 = r_p_pay.vx;
        n_out.new_vy                 = r_p_pay.vy;
        n_out.new_self_mass          = r_p_pay.ms;
        n_out.new_other_mass         = r_p_pay.mo;
        if (!r_p_pay.sgone && !r_p_pay.ogone) begin
            if (r_p_pay.merge) begin
                if ((r_p_pay.ms < r_p_pay.mo) && !r_p_pay.fixed) begin
                    n_out.self_removed           = 1'b1;
                    n_out.new_other_mass         = r_p_pay.msat;
                    n_out.other_velocity_cleared = 1'b1;
                end else begin
                    n_out.other_removed = 1'b1;
                    n_out.new_self_mass = r_p_pay.msat;
                    n_out.new_vx        = '0;
                    n_out.new_vy        = '0;
                end
            end else if (!r_p_pay.fixed) begin
                n_out.new_vx = r_p_wx;
                n_out.new_vy = r_p_wy;
                n_out.new_x  = sat32({{8{r_p_pay.sx[31]}}, r_p_pay.sx}
                                   + {{7{n_o_mvx[32]}}, n_o_mvx});
                n_out.new_y  = sat32({{8{r_p_pay.sy[31]}}, r_p_pay.sy}
                                   + {{7{n_o_mvy[32]}}, n_o_mvy});
            end
        end
    end

    // Output register: load when empty or taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (m_axis_tready || !r_out_valid) begin
            r_out_valid <= r_vp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_axis_tready || !r_out_valid) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // Checks
    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready && r_vp) |-> !s_axis_tready)
        else $error("input taken while pipeline is blocked");

    a_one_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.self_removed && r_out.other_removed))
        else $error("both particles removed");

    a_clear_with_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.other_velocity_cleared) |-> r_out.self_removed)
        else $error("velocity clear without self removal");

    a_absorb_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.other_removed) |-> (r_out.new_vx == '0 && r_out.new_vy == '0))
        else $error("absorbing particle keeps velocity");

endmodule

`default_nettype wire
